[rtl/core/patb_pkg.sv]
package patb_pkg;

	localparam int ALARM_SLOTS_DEF = 8;
	localparam int DELAY_BITS_DEF  = 23;
	localparam int ID_W            = 8;
	localparam int DELAY_MS_W      = 23;
	localparam int RES_W           = 2;

	typedef enum logic [RES_W-1:0] {
		RES_EXPIRED    = 2'd0,
		RES_PROGRAMMED = 2'd1,
		RES_CANCELLED  = 2'd2,
		RES_FULL       = 2'd3
	} event_res_t;

	typedef enum logic [1:0] {
		SLOT_NOP,
		SLOT_SET,
		SLOT_CLR
	} slot_op_t;

	typedef struct packed {
		slot_op_t        op;
		logic            periodic;
		logic [ID_W-1:0] id;
	} slot_cmd_t;

	typedef struct packed {
		logic hit;
		logic room;
	} slot_srch_t;

	typedef struct packed {
		logic            active;
		logic            periodic;
		logic [ID_W-1:0] id;
	} slot_view_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FLUSH
	} patb_state_t;

endpackage

[rtl/core/patb_ram.sv]
module patb_ram #(
	parameter int DEPTH  = patb_pkg::ALARM_SLOTS_DEF,
	parameter int WIDTH  = 2 * patb_pkg::DELAY_BITS_DEF,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/patb_slots.sv]
module patb_slots #(
	parameter int ALARM_SLOTS = patb_pkg::ALARM_SLOTS_DEF,
	parameter int SLOT_W      = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [patb_pkg::ID_W-1:0]   id,
	output patb_pkg::slot_srch_t        srch,
	output logic [SLOT_W-1:0]           hit_idx,
	output logic [SLOT_W-1:0]           free_idx,
	input  logic [SLOT_W-1:0]           scan_idx,
	output patb_pkg::slot_view_t        view,
	input  patb_pkg::slot_cmd_t         cmd,
	input  logic [SLOT_W-1:0]           cmd_idx
);

	logic [ALARM_SLOTS-1:0]    active_q;
	logic [ALARM_SLOTS-1:0]    per_q;
	logic [patb_pkg::ID_W-1:0] id_q [ALARM_SLOTS];

	// The search runs from the top down so that the lowest matching slot wins.
	always_comb begin
		srch     = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
			if (active_q[i] && (id_q[i] == id)) begin
				srch.hit = 1'b1;
				hit_idx  = SLOT_W'(i);
			end
			if (!active_q[i]) begin
				srch.room = 1'b1;
				free_idx  = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		view.active   = active_q[scan_idx];
		view.periodic = per_q[scan_idx];
		view.id       = id_q[scan_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			per_q    <= '0;
			for (int i = 0; i < ALARM_SLOTS; i++) begin
				id_q[i] <= '0;
			end
		end else begin
			unique case (cmd.op)
				patb_pkg::SLOT_SET: begin
					active_q[cmd_idx] <= 1'b1;
					per_q[cmd_idx]    <= cmd.periodic;
					id_q[cmd_idx]     <= cmd.id;
				end
				patb_pkg::SLOT_CLR: begin
					active_q[cmd_idx] <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/periodic_alarm_timer_bank.sv]
// A program word (kind 0) is taken from idle, busy stays low, and its single
// result appears on the cycle after acceptance. A tick word (kind 1) raises busy
// for a scan in which the sequencer reads one slot per cycle from the count
// memory, decrements each active count and writes it back, so the slot count sets
// the tick time. Expiry words come in slot order, one per cycle at most, and
// last marks the final one; a tick with no expiry produces no word. Results are
// shown for one cycle on strobe and must be taken then, since the receiver
// cannot hold them off.
module periodic_alarm_timer_bank #(
	parameter int ALARM_SLOTS = patb_pkg::ALARM_SLOTS_DEF,
	parameter int DELAY_BITS  = patb_pkg::DELAY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [patb_pkg::ID_W-1:0]       alarm_id,
	input  logic                            periodic,
	input  logic [patb_pkg::DELAY_MS_W-1:0] delay_ms,
	output logic                            strobe,
	output logic [patb_pkg::RES_W-1:0]      event_res,
	output logic [patb_pkg::ID_W-1:0]       event_id,
	output logic                            last
);

	localparam int SLOT_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
	localparam int LD_W   = (DELAY_BITS < patb_pkg::DELAY_MS_W) ? DELAY_BITS :
		patb_pkg::DELAY_MS_W;
	localparam int WORD_W = 2 * DELAY_BITS;

	patb_pkg::patb_state_t state_q, state_d;
	logic [SLOT_W-1:0]     idx_q, idx_d;
	logic                  vld_s1, vld_s1_d;
	logic [SLOT_W-1:0]     idx_s1;
	logic                  pend_vld_q, pend_vld_d;
	logic [patb_pkg::ID_W-1:0] pend_id_q, pend_id_d;

	logic                      strobe_q, strobe_d;
	patb_pkg::event_res_t      res_q, res_d;
	logic [patb_pkg::ID_W-1:0] id_out_q, id_out_d;
	logic                      last_q, last_d;

	patb_pkg::slot_srch_t srch;
	logic [SLOT_W-1:0]    hit_idx, free_idx, cmd_idx;
	patb_pkg::slot_view_t view;
	patb_pkg::slot_cmd_t  cmd;

	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]     ram_wdata, ram_rdata;
	logic [DELAY_BITS-1:0] delay_v, rd_rem, rd_reload, dec;

	assign delay_v   = DELAY_BITS'(delay_ms[LD_W-1:0]);
	assign rd_rem    = ram_rdata[DELAY_BITS-1:0];
	assign rd_reload = ram_rdata[WORD_W-1:DELAY_BITS];
	assign dec       = rd_rem - DELAY_BITS'(1);

	patb_slots #(
		.ALARM_SLOTS(ALARM_SLOTS),
		.SLOT_W     (SLOT_W)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.id      (alarm_id),
		.srch    (srch),
		.hit_idx (hit_idx),
		.free_idx(free_idx),
		.scan_idx(idx_s1),
		.view    (view),
		.cmd     (cmd),
		.cmd_idx (cmd_idx)
	);

	patb_ram #(
		.DEPTH (ALARM_SLOTS),
		.WIDTH (WORD_W),
		.ADDR_W(SLOT_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		vld_s1_d    = 1'b0;
		pend_vld_d  = pend_vld_q;
		pend_id_d   = pend_id_q;
		strobe_d    = 1'b0;
		res_d       = res_q;
		id_out_d    = id_out_q;
		last_d      = last_q;
		cmd.op       = patb_pkg::SLOT_NOP;
		cmd.periodic = periodic;
		cmd.id       = alarm_id;
		cmd_idx     = idx_s1;
		ram_we      = 1'b0;
		ram_waddr   = idx_s1;
		ram_wdata   = {rd_reload, dec};

		unique case (state_q)
			patb_pkg::ST_IDLE: begin
				if (start && kind) begin
					state_d = patb_pkg::ST_SCAN;
					idx_d   = '0;
				end else if (start) begin
					strobe_d = 1'b1;
					id_out_d = alarm_id;
					last_d   = 1'b1;
					if (delay_v == '0) begin
						res_d = patb_pkg::RES_CANCELLED;
						if (srch.hit) begin
							cmd.op  = patb_pkg::SLOT_CLR;
							cmd_idx = hit_idx;
						end
					end else if (srch.hit || srch.room) begin
						res_d     = patb_pkg::RES_PROGRAMMED;
						cmd.op    = patb_pkg::SLOT_SET;
						cmd_idx   = srch.hit ? hit_idx : free_idx;
						ram_we    = 1'b1;
						ram_waddr = cmd_idx;
						ram_wdata = {delay_v, delay_v};
					end else begin
						res_d = patb_pkg::RES_FULL;
					end
				end
			end
			patb_pkg::ST_SCAN: begin
				vld_s1_d = 1'b1;
				if (idx_q == SLOT_W'(ALARM_SLOTS - 1)) begin
					state_d = patb_pkg::ST_DRAIN;
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end
			patb_pkg::ST_DRAIN: begin
				state_d = patb_pkg::ST_FLUSH;
			end
			patb_pkg::ST_FLUSH: begin
				state_d = patb_pkg::ST_IDLE;
				if (pend_vld_q) begin
					strobe_d   = 1'b1;
					res_d      = patb_pkg::RES_EXPIRED;
					id_out_d   = pend_id_q;
					last_d     = 1'b1;
					pend_vld_d = 1'b0;
				end
			end
			default: begin
				state_d = patb_pkg::ST_IDLE;
			end
		endcase

		// One expiry is held back so that last can be set on the final one.
		if (vld_s1 && view.active) begin
			ram_we = 1'b1;
			if (dec == '0) begin
				if (view.periodic) begin
					ram_wdata = {rd_reload, rd_reload};
				end else begin
					cmd.op = patb_pkg::SLOT_CLR;
				end
				if (pend_vld_q) begin
					strobe_d = 1'b1;
					res_d    = patb_pkg::RES_EXPIRED;
					id_out_d = pend_id_q;
					last_d   = 1'b0;
				end
				pend_vld_d = 1'b1;
				pend_id_d  = view.id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= patb_pkg::ST_IDLE;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			vld_s1     <= vld_s1_d;
			idx_s1     <= idx_q;
			pend_vld_q <= pend_vld_d;
			strobe_q   <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_id_q <= pend_id_d;
		res_q     <= res_d;
		id_out_q  <= id_out_d;
		last_q    <= last_d;
	end

	assign busy      = (state_q != patb_pkg::ST_IDLE);
	assign strobe    = strobe_q;
	assign event_res = res_q;
	assign event_id  = id_out_q;
	assign last      = last_q;

	a_prog_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !kind |=> strobe && last)
		else $error("Program word did not give a single final result.");

	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == patb_pkg::ST_IDLE |-> !pend_vld_q)
		else $error("Expiry still held back after the tick finished.");

	a_mid_scan: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy && event_res == patb_pkg::RES_EXPIRED)
		else $error("Non-final result outside a tick scan.");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind |=> busy && !strobe)
		else $error("Tick word did not start a scan.");

endmodule
